// ===== rtl/core/cbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfp_pkg
// Shared types and constants for the camera block frame parser.
// ----------------------------------------------------------------------------
package cbfp_pkg;

    localparam logic [15:0] SYNC_WORD     = 16'haa55;
    localparam logic [15:0] SYNC_WORD_CC  = 16'haa56;
    localparam logic [15:0] SYNC_WORD_REV = 16'h55aa;
    localparam logic [15:0] IDLE_WORD     = 16'hffff;
    localparam logic [15:0] ZERO_WORD     = 16'h0000;

    // Index of the last data word within a block
    localparam logic [2:0]  LAST_DATA_IDX  = 3'd5;
    localparam logic [2:0]  FIRST_DATA_IDX = 3'd1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CSUM = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // One verified block
    typedef struct packed {
        logic [15:0] block_checksum;
        logic [15:0] signature;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] obj_width;
        logic [15:0] obj_height;
    } block_result_t;

    // Control from the frame parser back to the word packer
    typedef struct packed {
        logic word_take;
        logic drop_set;
    } pack_ctrl_t;

endpackage

// ===== rtl/core/cbfp_word_pack.sv =====
// ----------------------------------------------------------------------------
// cbfp_word_pack
// Pairs bytes into little-endian words and drops one byte on request.
// ----------------------------------------------------------------------------
module cbfp_word_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_advance,
    input  logic [7:0]          byte_data,
    input  cbfp_pkg::pack_ctrl_t ctrl,
    output logic                word_avail,
    output logic [15:0]         word
);
    import cbfp_pkg::*;

    logic       half_reg;
    logic       half_next;
    logic [7:0] low_reg;
    logic [7:0] low_next;
    logic       drop_reg;
    logic       drop_next;

    // Present a word when the held beat completes one
    assign word_avail = byte_valid && !drop_reg && half_reg;
    assign word       = {byte_data, low_reg};

    // Advance pairing state on each consumed beat
    always_comb
    begin
        half_next = half_reg;
        low_next  = low_reg;
        drop_next = drop_reg;
        if (byte_advance)
        begin
            if (drop_reg)
            begin
                drop_next = 1'b0;
            end
            else if (!half_reg)
            begin
                low_next  = byte_data;
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                drop_next = ctrl.word_take && ctrl.drop_set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            low_reg  <= 8'd0;
            drop_reg <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            low_reg  <= low_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== rtl/core/cbfp_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// cbfp_frame_fsm
// Sync hunt, checksum and data word capture with additive checksum check.
// ----------------------------------------------------------------------------
module cbfp_frame_fsm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    word_take,
    input  logic [15:0]             word,
    output logic                    drop_req,
    output logic                    result_hit,
    output cbfp_pkg::block_result_t result
);
    import cbfp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] prev_reg;
    logic [15:0] prev_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [15:0] cap_reg [0:4];
    logic [2:0]  idx;
    logic [15:0] sum_add;
    logic        is_sync;

    // Normalize the data word index into 1..5
    assign idx     = (cnt_reg == 3'd0 || cnt_reg > LAST_DATA_IDX) ? FIRST_DATA_IDX : cnt_reg;
    assign sum_add = sum_reg + word;
    assign is_sync = (word == SYNC_WORD) || (word == SYNC_WORD_CC);

    assign result_hit = (phase_reg == PH_DATA) && (idx == LAST_DATA_IDX)
                        && (sum_add == cap_reg[0]);
    assign result     = '{block_checksum: cap_reg[0], signature: cap_reg[1],
                          pos_x: cap_reg[2], pos_y: cap_reg[3],
                          obj_width: cap_reg[4], obj_height: word};

    // Next phase, previous word, counter and sum
    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        drop_req   = 1'b0;
        unique case (phase_reg)
            PH_CSUM:
            begin
                if (is_sync || word == ZERO_WORD)
                begin
                    phase_next = PH_HUNT;
                    prev_next  = IDLE_WORD;
                    cnt_next   = 3'd0;
                    sum_next   = 16'd0;
                end
                else
                begin
                    phase_next = PH_DATA;
                    cnt_next   = FIRST_DATA_IDX;
                    sum_next   = 16'd0;
                end
            end
            PH_DATA:
            begin
                if (idx == LAST_DATA_IDX)
                begin
                    phase_next = PH_HUNT;
                    prev_next  = IDLE_WORD;
                    cnt_next   = 3'd0;
                    sum_next   = 16'd0;
                end
                else
                begin
                    cnt_next = idx + 3'd1;
                    sum_next = sum_add;
                end
            end
            default:
            begin
                if (word == ZERO_WORD && prev_reg == ZERO_WORD)
                begin
                    phase_next = PH_HUNT;
                    prev_next  = IDLE_WORD;
                    cnt_next   = 3'd0;
                    sum_next   = 16'd0;
                end
                else if (prev_reg == SYNC_WORD && is_sync)
                begin
                    phase_next = PH_CSUM;
                    cnt_next   = 3'd0;
                    sum_next   = 16'd0;
                end
                else
                begin
                    drop_req  = (word == SYNC_WORD_REV);
                    prev_next = word;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= IDLE_WORD;
            cnt_reg   <= 3'd0;
            sum_reg   <= 16'd0;
        end
        else if (word_take)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    // Capture checksum and data words
    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            if (phase_reg == PH_CSUM)
            begin
                cap_reg[0] <= word;
            end
            else if (phase_reg == PH_DATA && idx != LAST_DATA_IDX)
            begin
                cap_reg[idx] <= word;
            end
        end
    end

endmodule

// ===== rtl/core/cbfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// cbfp_out_reg
// Result register on the master side of the parser.
// ----------------------------------------------------------------------------
module cbfp_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  cbfp_pkg::block_result_t result,
    input  logic                    m_axis_tready,
    output logic                    m_axis_tvalid,
    output logic [95:0]             m_axis_tdata
);
    import cbfp_pkg::*;

    logic          valid_reg;
    block_result_t data_reg;

    // Hold a result until the downstream beat completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.obj_height, data_reg.obj_width, data_reg.pos_y,
                            data_reg.pos_x, data_reg.signature, data_reg.block_checksum};

endmodule

// ===== rtl/core/camera_block_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// camera_block_frame_parser_top
// Byte stream to verified object block parser.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and can accept a byte every
// clock cycle. Each byte is held in an input register and handled in the
// next cycle; a verified block is loaded into the output register when the
// byte that completes its last data word is handled. A byte waits in the input
// register only when it completes a block while the previous block has not
// yet been taken downstream.
module camera_block_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // block_checksum, signature, pos_x, pos_y,
                                        // obj_width, obj_height (16 bits each)
);
    import cbfp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          word_avail;
    logic [15:0]   word;
    logic          drop_req;
    logic          result_hit;
    block_result_t result;
    logic          out_stall;
    logic          fire;
    logic          word_take;
    pack_ctrl_t    pack_ctrl;

    // Consume the held beat unless its result has nowhere to go
    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign fire          = in_valid_reg && !(word_avail && result_hit && out_stall);
    assign word_take     = fire && word_avail;
    assign s_axis_tready = !in_valid_reg || fire;
    assign pack_ctrl     = '{word_take: word_take, drop_set: drop_req};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    cbfp_word_pack u_word_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (in_valid_reg),
        .byte_advance (fire),
        .byte_data    (in_byte_reg),
        .ctrl         (pack_ctrl),
        .word_avail   (word_avail),
        .word         (word)
    );

    cbfp_frame_fsm u_frame_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_take  (word_take),
        .word       (word),
        .drop_req   (drop_req),
        .result_hit (result_hit),
        .result     (result)
    );

    cbfp_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (word_take && result_hit),
        .result        (result),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the camera block frame parser.
// ----------------------------------------------------------------------------
// Bytes go in one beat at a time through the input stream. A byte-level
// tracker of the parser runs beside the block and queues the block it should
// publish. Every output beat is compared field by field against the oldest
// queued block. Directed tests cover good blocks, the sync variants, bad and
// reserved checksums, the zero-word restart and the byte drop after 0x55aa.
// A long output stall and a full drain follow, then a random phase mixes
// well-formed blocks with noise and cut frames, with random gaps on both sides.
module tb;
    import cbfp_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    // Tracker state, mirrors the parser
    phase_t      trk_phase;
    logic        trk_half;
    logic [7:0]  trk_low;
    logic        trk_drop;
    logic [15:0] trk_prev;
    logic [2:0]  trk_count;
    logic [15:0] trk_sum;
    logic [15:0] trk_words [6];

    // Blocks the parser still owes, checksum in the low 16 bits
    logic [95:0] pending_blocks [$];

    int    error_count;
    int    bytes_sent;
    int    idle_cycles = 0;
    bit    tx_idle;
    bit    rx_idle;
    int    rx_gap;
    bit    rx_hold;
    bit    hold_start;
    string field_name [6] = '{"block_checksum", "signature", "pos_x", "pos_y",
                              "obj_width", "obj_height"};

    camera_block_frame_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Return the tracker to hunting with a fresh previous word
    task automatic restart_hunt();
        trk_phase = PH_HUNT;
        trk_prev  = IDLE_WORD;
        trk_count = 3'd0;
        trk_sum   = 16'd0;
    endtask

    // Advance the tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        logic [15:0] w;
        logic [2:0]  idx;
        if (trk_drop)
        begin
            trk_drop = 1'b0;
        end
        else if (!trk_half)
        begin
            trk_low  = b;
            trk_half = 1'b1;
        end
        else
        begin
            trk_half = 1'b0;
            w = {b, trk_low};
            case (trk_phase)
                PH_CSUM:
                begin
                    if (w == SYNC_WORD || w == SYNC_WORD_CC || w == ZERO_WORD)
                        restart_hunt();
                    else
                    begin
                        trk_words[0] = w;
                        trk_sum      = 16'd0;
                        trk_count    = FIRST_DATA_IDX;
                        trk_phase    = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    idx = trk_count;
                    if (idx < FIRST_DATA_IDX || idx > LAST_DATA_IDX)
                        idx = FIRST_DATA_IDX;
                    trk_words[idx] = w;
                    trk_sum = trk_sum + w;
                    if (idx == LAST_DATA_IDX)
                    begin
                        if (trk_sum == trk_words[0])
                            pending_blocks.push_back({trk_words[5], trk_words[4],
                                                      trk_words[3], trk_words[2],
                                                      trk_words[1], trk_words[0]});
                        restart_hunt();
                    end
                    else
                        trk_count = idx + 3'd1;
                end
                default:
                begin
                    if (w == ZERO_WORD && trk_prev == ZERO_WORD)
                        restart_hunt();
                    else if (trk_prev == SYNC_WORD &&
                             (w == SYNC_WORD || w == SYNC_WORD_CC))
                    begin
                        trk_phase = PH_CSUM;
                        trk_count = 3'd0;
                        trk_sum   = 16'd0;
                    end
                    else
                    begin
                        if (w == SYNC_WORD_REV)
                            trk_drop = 1'b1;
                        trk_prev = w;
                    end
                end
            endcase
        end
    endtask

    // Offer one byte, after a random gap when tx_idle is set, hold until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    // Drop tvalid before any wait that is not a handshake
    task automatic tx_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    // Sum of five data words, first word in the low bits
    function automatic logic [15:0] data_sum(input logic [79:0] data);
        logic [15:0] s;
        s = 16'd0;
        for (int i = 0; i < 5; i++)
            s = s + data[16*i +: 16];
        return s;
    endfunction

    task automatic send_block(input logic [15:0] sync2, input logic [15:0] csum,
                              input logic [79:0] data);
        send_word(SYNC_WORD);
        send_word(sync2);
        send_word(csum);
        for (int i = 0; i < 5; i++)
            send_word(data[16*i +: 16]);
    endtask

    // Feed filler bytes until the parser hunts on a word boundary
    task automatic sync_to_hunt();
        while (trk_half || trk_drop || trk_phase != PH_HUNT || trk_prev == SYNC_WORD)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [15:0] rand_data_word();
        case ($urandom_range(0, 7))
            0:       return ZERO_WORD;
            1:       return IDLE_WORD;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_good_blocks();
        logic [79:0] d;
        d = {5{16'hffff}};
        send_block(SYNC_WORD, data_sum(d), d);
        d = {16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        send_block(SYNC_WORD_CC, data_sum(d), d);
    endtask

    task automatic test_checksum_mismatch();
        logic [79:0] d;
        d = {16'h0050, 16'h0060, 16'h8000, 16'h7fff, 16'h0012};
        send_block(SYNC_WORD, data_sum(d) + 16'd1, d);
    endtask

    // Reserved checksum values abandon the block
    task automatic test_reserved_checksum();
        logic [79:0] d;
        d = {5{16'h1234}};
        send_block(SYNC_WORD, SYNC_WORD, d);
        send_block(SYNC_WORD_CC, SYNC_WORD_CC, d);
        send_block(SYNC_WORD, ZERO_WORD, d);
    endtask

    task automatic test_zero_restart();
        logic [79:0] d;
        send_word(SYNC_WORD);
        send_word(ZERO_WORD);
        send_word(ZERO_WORD);
        d = {16'h0004, 16'h0003, 16'h0002, 16'h0001, 16'h00ff};
        send_block(SYNC_WORD, data_sum(d), d);
    endtask

    // 0x55aa swallows the next byte; also start a block off by one byte
    task automatic test_realign();
        logic [79:0] d;
        d = {16'h0140, 16'h00c8, 16'h0080, 16'h0100, 16'h0002};
        send_word(SYNC_WORD_REV);
        send_byte(8'h77);
        send_block(SYNC_WORD, data_sum(d), d);
        send_byte(8'h42);
        send_block(SYNC_WORD_CC, data_sum(d), d);
    endtask

    task automatic test_random();
        int          target;
        int          n;
        logic [79:0] d;
        logic [15:0] csum;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                tx_idle = $urandom_range(0, 1);
                rx_idle = $urandom_range(0, 1);
            end
            for (int i = 0; i < 5; i++)
                d[16*i +: 16] = rand_data_word();
            csum = data_sum(d);
            if ($urandom_range(0, 4) == 0)
                csum = csum + 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 9))
                7:
                begin
                    // noise bytes
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_byte(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    // lone special words
                    case ($urandom_range(0, 2))
                        0: send_word(SYNC_WORD_REV);
                        1: begin send_word(ZERO_WORD); send_word(ZERO_WORD); end
                        default: send_word(SYNC_WORD);
                    endcase
                end
                9:
                begin
                    // block that may be cut short, the stream carries on
                    sync_to_hunt();
                    n = $urandom_range(1, 15);
                    send_word(SYNC_WORD);
                    send_word($urandom_range(0, 1) ? SYNC_WORD : SYNC_WORD_CC);
                    send_word(csum);
                    for (int i = 0; i < 5 && n > 6 + 2 * i; i++)
                        send_word(d[16*i +: 16]);
                end
                default:
                begin
                    sync_to_hunt();
                    send_block($urandom_range(0, 1) ? SYNC_WORD : SYNC_WORD_CC, csum, d);
                end
            endcase
        end
    endtask

    // Output held off for a long stretch while blocks keep coming
    task automatic test_backpressure();
        logic [79:0] d;
        tx_idle = 1'b0;
        hold_start = 1'b1;
        repeat (6)
        begin
            for (int i = 0; i < 5; i++)
                d[16*i +: 16] = 16'($urandom);
            sync_to_hunt();
            send_block(SYNC_WORD, data_sum(d), d);
        end
        tx_idle = 1'b1;
    endtask

    // Input pauses until every owed block has been published
    task automatic test_drain_pause();
        logic [79:0] d;
        d = {16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0005};
        sync_to_hunt();
        send_block(SYNC_WORD_CC, data_sum(d), d);
        tx_quiet();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        send_block(SYNC_WORD, data_sum(d), d);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        error_count   = 0;
        bytes_sent    = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        hold_start    = 1'b0;
        trk_half      = 1'b0;
        trk_low       = 8'd0;
        trk_drop      = 1'b0;
        for (int i = 0; i < 6; i++)
            trk_words[i] = 16'd0;
        restart_hunt();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_good_blocks();
        test_checksum_mismatch();
        test_reserved_checksum();
        test_zero_restart();
        test_realign();
        test_backpressure();
        test_drain_pause();
        test_random();

        tx_quiet();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Long output hold-off, counted here
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                rx_hold    = 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rx_hold = 1'b0;
            end
        end
    end

    // Drive output tready with random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        rx_gap        = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold || !rst_n)
                m_axis_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest owed block
    always @(posedge clk)
    begin : check_output
        logic [95:0] exp_blk;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (pending_blocks.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected block, expected none, actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                exp_blk = pending_blocks.pop_front();
                for (int i = 0; i < 6; i++)
                    if (exp_blk[16*i +: 16] !== m_axis_tdata[16*i +: 16])
                    begin
                        error_count++;
                        $display("%0t: %s expected %h actual %h", $time, field_name[i],
                                 exp_blk[16*i +: 16], m_axis_tdata[16*i +: 16]);
                    end
            end
        end
    end

    // End the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
